// ===== rtl/core/tts_pkg.sv =====
// Shared constants and types of the tournament tree sorter.
`timescale 1ns / 1ps

package tts_pkg;

    localparam int LEAF_COUNT  = 64;
    localparam int INNER_COUNT = LEAF_COUNT - 1;
    localparam int CAPACITY    = 64;
    localparam int LEAF_W      = $clog2(LEAF_COUNT);
    localparam int NODE_W      = LEAF_W + 1;
    localparam int CNT_W       = $clog2(LEAF_COUNT + 1);
    localparam int VALUE_W     = 32;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value_in;
        logic                      last_in;
    } tts_in_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value_out;
        logic                      last_out;
    } tts_out_t;

    typedef struct packed {
        logic              load;
        logic [LEAF_W-1:0] load_idx;
        logic              read;
        logic              play;
        logic [LEAF_W-1:0] node;
        logic              emit;
        logic              emit_last;
        logic              clear;
    } tts_cmd_t;

    typedef struct packed {
        logic [LEAF_W-1:0] root_leaf;
    } tts_status_t;

endpackage

// ===== rtl/core/tts_datapath.sv =====
// Leaf and node storage, match logic and result register of the sorter.
`timescale 1ns / 1ps

module tts_datapath
    import tts_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  tts_cmd_t    cmd,
    input  tts_in_t     item,
    output tts_status_t status,
    output tts_out_t    result,
    output logic        result_valid
);

    logic signed [VALUE_W-1:0] leaf_mem [0:LEAF_COUNT-1];
    logic signed [VALUE_W-1:0] node_val_mem [0:INNER_COUNT-1];
    logic [LEAF_W-1:0]         node_leaf_mem [0:INNER_COUNT-1];

    logic [LEAF_COUNT-1:0]  leaf_live_reg;
    logic [INNER_COUNT-1:0] node_live_reg;

    logic [NODE_W-1:0] child_a;
    logic [NODE_W-1:0] child_b;
    logic [LEAF_W-1:0] leaf_a;
    logic [LEAF_W-1:0] leaf_b;
    logic [LEAF_W-1:0] naddr_a;
    logic [LEAF_W-1:0] naddr_b;
    logic              is_bottom;

    // registered read stage
    logic                      bottom_reg;
    logic [LEAF_W-1:0]         p_reg;
    logic [LEAF_W-1:0]         leaf_a_reg;
    logic [LEAF_W-1:0]         leaf_b_reg;
    logic                      live_a_reg;
    logic                      live_b_reg;
    logic signed [VALUE_W-1:0] lval_a_reg;
    logic signed [VALUE_W-1:0] lval_b_reg;
    logic signed [VALUE_W-1:0] nval_a_reg;
    logic signed [VALUE_W-1:0] nval_b_reg;
    logic [LEAF_W-1:0]         nleaf_a_reg;
    logic [LEAF_W-1:0]         nleaf_b_reg;

    logic signed [VALUE_W-1:0] a_val;
    logic signed [VALUE_W-1:0] b_val;
    logic [LEAF_W-1:0]         a_leaf;
    logic [LEAF_W-1:0]         b_leaf;
    logic                      sel_b;
    logic signed [VALUE_W-1:0] win_val;
    logic [LEAF_W-1:0]         win_leaf;
    logic                      win_live;

    logic signed [VALUE_W-1:0] root_val_reg;
    logic [LEAF_W-1:0]         root_leaf_reg;
    tts_out_t                  result_reg;
    logic                      valid_reg;

    assign child_a   = {cmd.node, 1'b1};
    assign child_b   = child_a + NODE_W'(1);
    assign is_bottom = (child_a >= NODE_W'(INNER_COUNT));
    assign leaf_a    = LEAF_W'(child_a - NODE_W'(INNER_COUNT));
    assign leaf_b    = LEAF_W'(child_b - NODE_W'(INNER_COUNT));
    assign naddr_a   = is_bottom ? '0 : child_a[LEAF_W-1:0];
    assign naddr_b   = is_bottom ? '0 : child_b[LEAF_W-1:0];

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            leaf_mem[cmd.load_idx] <= item.value_in;
        end
        if (cmd.read)
        begin
            lval_a_reg  <= leaf_mem[leaf_a];
            lval_b_reg  <= leaf_mem[leaf_b];
            nval_a_reg  <= node_val_mem[naddr_a];
            nval_b_reg  <= node_val_mem[naddr_b];
            nleaf_a_reg <= node_leaf_mem[naddr_a];
            nleaf_b_reg <= node_leaf_mem[naddr_b];
            bottom_reg  <= is_bottom;
            p_reg       <= cmd.node;
            leaf_a_reg  <= leaf_a;
            leaf_b_reg  <= leaf_b;
            live_a_reg  <= is_bottom ? leaf_live_reg[leaf_a] : node_live_reg[naddr_a];
            live_b_reg  <= is_bottom ? leaf_live_reg[leaf_b] : node_live_reg[naddr_b];
        end
        if (cmd.play)
        begin
            node_val_mem[p_reg]  <= win_val;
            node_leaf_mem[p_reg] <= win_leaf;
            if (p_reg == '0)
            begin
                root_val_reg  <= win_val;
                root_leaf_reg <= win_leaf;
            end
        end
        if (cmd.emit)
        begin
            result_reg.value_out <= root_val_reg;
            result_reg.last_out  <= cmd.emit_last;
        end
    end

    always_comb
    begin
        a_val    = bottom_reg ? lval_a_reg : nval_a_reg;
        b_val    = bottom_reg ? lval_b_reg : nval_b_reg;
        a_leaf   = bottom_reg ? leaf_a_reg : nleaf_a_reg;
        b_leaf   = bottom_reg ? leaf_b_reg : nleaf_b_reg;
        sel_b    = live_b_reg && (!live_a_reg || !(a_val < b_val));
        win_val  = sel_b ? b_val : a_val;
        win_leaf = sel_b ? b_leaf : a_leaf;
        win_live = live_a_reg || live_b_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            leaf_live_reg <= '0;
            node_live_reg <= '0;
            valid_reg     <= 1'b0;
        end
        else
        begin
            valid_reg <= cmd.emit;
            if (cmd.clear)
            begin
                leaf_live_reg <= '0;
                node_live_reg <= '0;
            end
            else
            begin
                if (cmd.load)
                begin
                    leaf_live_reg[cmd.load_idx] <= 1'b1;
                end
                if (cmd.emit)
                begin
                    leaf_live_reg[root_leaf_reg] <= 1'b0;
                end
                if (cmd.play)
                begin
                    node_live_reg[p_reg] <= win_live;
                end
            end
        end
    end

    assign status.root_leaf = root_leaf_reg;
    assign result           = result_reg;
    assign result_valid     = valid_reg;

endmodule

// ===== rtl/core/tts_ctrl.sv =====
// Sequencer for loading, tournament build, emission and path replay.
`timescale 1ns / 1ps

module tts_ctrl
    import tts_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  tts_in_t     item,
    input  tts_status_t status,
    output tts_cmd_t    cmd,
    output logic        busy
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_BUILD_RD,
        ST_BUILD_PLAY,
        ST_EMIT,
        ST_CLIMB_RD,
        ST_CLIMB_PLAY
    } state_t;

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  remain_reg, remain_next;
    logic [LEAF_W-1:0] node_reg, node_next;
    logic              busy_reg, busy_next;
    logic              can_load;
    logic [NODE_W-1:0] leaf_parent;

    assign can_load    = (count_reg < CNT_W'(CAPACITY));
    assign leaf_parent = (NODE_W'(status.root_leaf) + NODE_W'(INNER_COUNT - 1)) >> 1;

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        remain_next = remain_reg;
        node_next   = node_reg;
        busy_next   = busy_reg;
        cmd         = '0;
        cmd.node    = node_reg;
        cmd.load_idx = count_reg[LEAF_W-1:0];
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    if (can_load)
                    begin
                        cmd.load   = 1'b1;
                        count_next = count_reg + CNT_W'(1);
                    end
                    if (item.last_in)
                    begin
                        remain_next = count_next;
                        node_next   = LEAF_W'(INNER_COUNT - 1);
                        state_next  = ST_BUILD_RD;
                        busy_next   = 1'b1;
                    end
                end
            end
            ST_BUILD_RD:
            begin
                cmd.read   = 1'b1;
                state_next = ST_BUILD_PLAY;
            end
            ST_BUILD_PLAY:
            begin
                cmd.play = 1'b1;
                if (node_reg == '0)
                begin
                    state_next = ST_EMIT;
                end
                else
                begin
                    node_next  = node_reg - LEAF_W'(1);
                    state_next = ST_BUILD_RD;
                end
            end
            ST_EMIT:
            begin
                cmd.emit = 1'b1;
                if (remain_reg == CNT_W'(1))
                begin
                    cmd.emit_last = 1'b1;
                    cmd.clear     = 1'b1;
                    count_next    = '0;
                    remain_next   = '0;
                    state_next    = ST_IDLE;
                    busy_next     = 1'b0;
                end
                else
                begin
                    remain_next = remain_reg - CNT_W'(1);
                    node_next   = leaf_parent[LEAF_W-1:0];
                    state_next  = ST_CLIMB_RD;
                end
            end
            ST_CLIMB_RD:
            begin
                cmd.read   = 1'b1;
                state_next = ST_CLIMB_PLAY;
            end
            ST_CLIMB_PLAY:
            begin
                cmd.play = 1'b1;
                if (node_reg == '0)
                begin
                    state_next = ST_EMIT;
                end
                else
                begin
                    node_next  = (node_reg - LEAF_W'(1)) >> 1;
                    state_next = ST_CLIMB_RD;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
                busy_next  = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            count_reg  <= '0;
            remain_reg <= '0;
            node_reg   <= '0;
            busy_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            remain_reg <= remain_next;
            node_reg   <= node_next;
            busy_reg   <= busy_next;
        end
    end

    assign busy = busy_reg;

endmodule

// ===== rtl/core/tournament_tree_sorter.sv =====
// Top level of the winner-tree sorter: sequencer plus tree datapath.
// Loading: one value per cycle while busy is low; the beat with last_in set raises busy.
// Build: a read of the children and then a play for each of the 63 inner nodes.
// Each result: an emit, then a read and a play for each of the six matches on the leaf's path,
// so results never come back to back; the receiver cannot stall and busy drops with the last.
// Reset (rst_n low, async) empties the tree and clears the load count.
`timescale 1ns / 1ps

module tournament_tree_sorter
    import tts_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    output logic     busy,
    input  tts_in_t  item,
    output tts_out_t result,
    output logic     result_valid
);

    tts_cmd_t    cmd;
    tts_status_t status;

    tts_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .item   (item),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    tts_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .item         (item),
        .status       (status),
        .result       (result),
        .result_valid (result_valid)
    );

endmodule

// ===== tb/tournament_tree_sorter_test.sv =====
// Self-checking testbench for tournament_tree_sorter: directed table, random sets, predictor.
`timescale 1ns / 1ps

module tournament_tree_sorter_test
    import tts_pkg::*;
();

    localparam logic signed [VALUE_W-1:0] VALUE_MIN = 32'sh8000_0000;
    localparam logic signed [VALUE_W-1:0] VALUE_MAX = 32'sh7FFF_FFFF;
    localparam int RANDOM_ITEMS  = 180;
    localparam int DRAIN_LIMIT   = 4000;
    localparam int SETTLE_CYCLES = 20;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic                      last;
        logic                      typed;
        logic signed [VALUE_W-1:0] want;
    } directed_row_t;

    logic     clk = 1'b0;
    logic     rst_n;
    logic     start;
    logic     busy;
    tts_in_t  load_beat;
    tts_out_t sorted_beat;
    logic     result_valid;

    logic signed [VALUE_W-1:0] loaded_sorted[$];
    tts_out_t                  sorted_expected[$];
    directed_row_t             directed_rows[$];
    tts_out_t                  want;

    int error_count;
    int items_sent;
    int sets_sorted;
    int values_checked;

    tournament_tree_sorter dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .item         (load_beat),
        .result       (sorted_beat),
        .result_valid (result_valid)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    initial
    begin
        #2_000_000;
        $display("tournament_tree_sorter verification failed");
        $finish;
    end

    // Keeps the loaded set in ascending order; a last beat releases the whole run.
    task automatic predict_beat(input tts_in_t beat, input bit push_results);
        int       pos;
        tts_out_t exp_beat;
        if (loaded_sorted.size() < CAPACITY)
        begin
            pos = 0;
            while (pos < loaded_sorted.size() && loaded_sorted[pos] <= $signed(beat.value_in))
                pos++;
            loaded_sorted.insert(pos, $signed(beat.value_in));
        end
        if (beat.last_in)
        begin
            if (push_results)
            begin
                foreach (loaded_sorted[i])
                begin
                    exp_beat.value_out = loaded_sorted[i];
                    exp_beat.last_out  = (i == loaded_sorted.size() - 1);
                    sorted_expected.push_back(exp_beat);
                end
            end
            loaded_sorted.delete();
            sets_sorted++;
        end
    endtask

    task automatic send_beat(input tts_in_t beat, input bit push_results);
        start     <= 1'b1;
        load_beat <= beat;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        predict_beat(beat, push_results);
        items_sent++;
    endtask

    // Inputs carry junk while start is low.
    task automatic idle_for(input int cycles);
        tts_in_t junk;
        junk.value_in = $urandom;
        junk.last_in  = $urandom_range(0, 1);
        start     <= 1'b0;
        load_beat <= junk;
        repeat (cycles)
            @(posedge clk);
    endtask

    task automatic pause_until_drained();
        start <= 1'b0;
        do
            @(posedge clk);
        while (sorted_expected.size() != 0);
    endtask

    function automatic logic signed [VALUE_W-1:0] random_value();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 60)
            return $urandom;
        if (pick < 75)
        begin
            case ($urandom_range(0, 4))
                0:       return VALUE_MIN;
                1:       return VALUE_MAX;
                2:       return 0;
                3:       return -1;
                default: return 1;
            endcase
        end
        return $urandom_range(0, 8) - 4;
    endfunction

    function automatic int random_set_size();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 80)
            return $urandom_range(1, 8);
        if (pick < 95)
            return $urandom_range(9, 24);
        return CAPACITY + $urandom_range(0, 3);
    endfunction

    task automatic send_random_set(input int size, input int idle_pct);
        tts_in_t beat;
        for (int n = 0; n < size; n++)
        begin
            while ($urandom_range(0, 99) < idle_pct)
                idle_for(1);
            beat.value_in = random_value();
            beat.last_in  = (n == size - 1);
            send_beat(beat, 1'b1);
        end
    endtask

    task automatic add_row(input logic signed [VALUE_W-1:0] value, input logic last,
                           input logic typed, input logic signed [VALUE_W-1:0] row_want);
        directed_row_t row;
        row.value = value;
        row.last  = last;
        row.typed = typed;
        row.want  = row_want;
        directed_rows.push_back(row);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && result_valid)
        begin
            if (sorted_expected.size() == 0)
            begin
                $error("unexpected result: value_out=%0d last_out=%0b",
                       sorted_beat.value_out, sorted_beat.last_out);
                error_count++;
            end
            else
            begin
                want = sorted_expected.pop_front();
                if (sorted_beat.value_out !== want.value_out)
                begin
                    $error("value_out mismatch: expected %0d, actual %0d",
                           want.value_out, sorted_beat.value_out);
                    error_count++;
                end
                if (sorted_beat.last_out !== want.last_out)
                begin
                    $error("last_out mismatch: expected %0b, actual %0b",
                           want.last_out, sorted_beat.last_out);
                    error_count++;
                end
                values_checked++;
            end
        end
    end

    initial
    begin
        tts_in_t  beat;
        tts_out_t typed_beat;
        int       phase_items;
        int       size;
        int       idle_pct;
        int       guard;

        rst_n          = 1'b0;
        start          = 1'b0;
        load_beat      = '0;
        error_count    = 0;
        items_sent     = 0;
        sets_sorted    = 0;
        values_checked = 0;

        // single-value sets: the value comes straight back as the last of its run
        add_row(VALUE_MIN, 1'b1, 1'b1, VALUE_MIN);
        add_row(VALUE_MAX, 1'b1, 1'b1, VALUE_MAX);
        add_row(0,         1'b1, 1'b1, 0);
        add_row(-1,        1'b1, 1'b1, -1);
        // ties
        add_row(7,  1'b0, 1'b0, 0);
        add_row(7,  1'b0, 1'b0, 0);
        add_row(-7, 1'b1, 1'b0, 0);
        // mixed signs and extremes
        add_row(VALUE_MAX, 1'b0, 1'b0, 0);
        add_row(-1,        1'b0, 1'b0, 0);
        add_row(VALUE_MIN, 1'b0, 1'b0, 0);
        add_row(0,         1'b0, 1'b0, 0);
        add_row(1,         1'b1, 1'b0, 0);
        // descending input, then a pair next to the extremes
        for (int v = 40; v >= -30; v -= 10)
            add_row(v, (v == -30), 1'b0, 0);
        add_row(32'sh8000_0001, 1'b0, 1'b0, 0);
        add_row(32'sh7FFF_FFFE, 1'b1, 1'b0, 0);

        repeat (10)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            if ($urandom_range(0, 99) < 20)
                idle_for($urandom_range(1, 3));
            beat.value_in = directed_rows[i].value;
            beat.last_in  = directed_rows[i].last;
            send_beat(beat, !directed_rows[i].typed);
            if (directed_rows[i].typed)
            begin
                typed_beat.value_out = directed_rows[i].want;
                typed_beat.last_out  = 1'b1;
                sorted_expected.push_back(typed_beat);
            end
        end
        pause_until_drained();

        for (int phase = 0; phase < 3; phase++)
        begin
            idle_pct    = (phase == 0) ? 35 : (phase == 1) ? 80 : 0;
            phase_items = 0;
            while (phase_items < RANDOM_ITEMS / 3)
            begin
                // one set at or past capacity is always included
                if (phase == 1 && phase_items == 0)
                    size = CAPACITY + $urandom_range(0, 3);
                else
                    size = random_set_size();
                send_random_set(size, idle_pct);
                phase_items += size;
            end
            pause_until_drained();
        end

        start <= 1'b0;
        guard = 0;
        while (sorted_expected.size() != 0 && guard < DRAIN_LIMIT)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (SETTLE_CYCLES)
            @(posedge clk);

        if (sorted_expected.size() != 0)
        begin
            $error("%0d sorted values never came out", sorted_expected.size());
            error_count++;
        end

        $display("Loaded %0d beats in %0d sets (one at or past capacity)",
                 items_sent, sets_sorted);
        $display("Checked %0d sorted values, sender gaps 35%%, 80%%, none; %0d errors",
                 values_checked, error_count);
        if (error_count == 0)
            $display("tournament_tree_sorter verification clean");
        else
            $display("tournament_tree_sorter verification failed");
        $finish;
    end

endmodule
